>>> rtl/core/actct_pkg.sv
`default_nettype none
package actct_pkg;

    localparam int DEF_MAX_STREAMS   = 8;
    localparam int DEF_MAX_LISTENERS = 16;

    localparam logic [1:0] FUNC_CONNECT    = 2'd0;
    localparam logic [1:0] FUNC_DISCONNECT = 2'd1;
    localparam logic [1:0] FUNC_TX_STATE   = 2'd2;
    localparam logic [1:0] FUNC_TX_CONN    = 2'd3;

    localparam logic [1:0] ST_SUCCESS         = 2'd0;
    localparam logic [1:0] ST_NO_STREAM_INDEX = 2'd1;
    localparam logic [1:0] ST_NO_SUCH_CONN    = 2'd2;

    localparam logic [1:0] REG_ENTITY_ID    = 2'd0;
    localparam logic [1:0] REG_TALKER_MAC   = 2'd1;
    localparam logic [1:0] REG_STREAM_COUNT = 2'd2;

    localparam logic [47:0] DEST_MAC_BASE = 48'h91e0f000fe00;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] addressed_entity_id;
        logic [15:0] stream_index;
        logic [63:0] listener_id;
        logic [15:0] listener_port;
        logic [15:0] connection_index;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  response_kind;
        logic [1:0]  status;
        logic [63:0] stream_tag;
        logic [47:0] dest_addr;
        logic [63:0] reply_listener_id;
        logic [15:0] reply_listener_port;
        logic [4:0]  connection_total;
        logic        notify;
    } rsp_t;

    // Pair carried between neighboring cells.
    typedef struct packed {
        logic        vld;
        logic [63:0] id;
        logic [15:0] port;
    } pair_t;

    // Per-cycle control broadcast to every cell.
    typedef struct packed {
        logic shift;
    } cell_ctl_t;

endpackage
`default_nettype wire

>>> rtl/core/actct_cell.sv
`default_nettype none
module actct_cell
    import actct_pkg::*;
(
    input  wire logic      aclk,
    input  wire cell_ctl_t ctl,
    input  wire pair_t     prev_pair,
    output pair_t          cur_pair
);
    // One slot of the rotating listener ring. On a shift the cell takes its
    // left neighbor's pair; the head cell gets a mux-selected pair instead.
    pair_t pair_reg;
    pair_t pair_next;

    always_comb begin
        pair_next = pair_reg;
        if (ctl.shift) begin
            pair_next = prev_pair;
        end
    end

    always_ff @(posedge aclk) begin
        pair_reg <= pair_next;
    end

    assign cur_pair = pair_reg;
endmodule
`default_nettype wire

>>> rtl/core/actct_chain.sv
`default_nettype none
module actct_chain
    import actct_pkg::*;
#(
    parameter int MAX_LISTENERS = DEF_MAX_LISTENERS
) (
    input  wire logic      aclk,
    input  wire cell_ctl_t ctl,
    input  wire pair_t     head_in,
    output pair_t          tail_out
);
    pair_t links [MAX_LISTENERS+1];

    assign links[0] = head_in;

    for (genvar g = 0; g < MAX_LISTENERS; g++) begin : g_cell
        actct_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .prev_pair (links[g]),
            .cur_pair  (links[g+1])
        );
    end

    assign tail_out = links[MAX_LISTENERS];
endmodule
`default_nettype wire

>>> rtl/core/acmp_talker_connection_table.sv
`default_nettype none
// Channel   | Ports            | Payload | Direction
// command   | s_valid/s_ready  | cmd_t   | in
// response  | m_valid/m_ready  | rsp_t   | out
// config    | cfg_we/cfg_index | 64 bit  | in, write only
//
// One request at a time. A stream's listener list is kept in a memory row per
// stream; the row is loaded into a chain of MAX_LISTENERS cells, rotated once
// through the chain while matching, dropping or reading pairs, and written
// back. A table request goes through one row read, the load pass, the rotate
// pass and one write-back before valid is raised in the response state.
// A bad-stream request goes from the row read straight to the response; a
// foreign request is dropped and the block returns to idle with no response.
// The block is ready again in the cycle after the response handshake.
// Reset (aresetn low at a clock edge) clears all fill counts; slot contents
// are left as they are. A stalled response holds, and the next request is
// accepted only after the response is taken.
module acmp_talker_connection_table
    import actct_pkg::*;
#(
    parameter int MAX_STREAMS   = DEF_MAX_STREAMS,
    parameter int MAX_LISTENERS = DEF_MAX_LISTENERS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire cmd_t        s_cmd,
    output logic             m_valid,
    input  wire logic        m_ready,
    output rsp_t             m_rsp,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    localparam int SW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam int LW = (MAX_LISTENERS > 1) ? $clog2(MAX_LISTENERS) : 1;
    localparam int FW = LW + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_ROT    = 3'd3;
    localparam logic [2:0] S_STORE  = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;

    // Configuration registers.
    logic [63:0] entity_id_reg;
    logic [47:0] mac_reg;
    logic [3:0]  stream_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entity_id_reg    <= '0;
            mac_reg          <= '0;
            stream_count_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ENTITY_ID:    entity_id_reg    <= cfg_data;
                REG_TALKER_MAC:   mac_reg          <= cfg_data[47:0];
                REG_STREAM_COUNT: stream_count_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Per-stream listener rows: one row holds all slots of a stream.
    logic [MAX_LISTENERS*80-1:0] row_mem [MAX_STREAMS];
    logic [MAX_LISTENERS*80-1:0] row_rd_reg;
    logic [MAX_LISTENERS*80-1:0] row_wr;
    logic                         row_we;

    logic [FW-1:0] fill_reg [MAX_STREAMS];

    logic [2:0]    state_reg, state_next;
    cmd_t          cmd_reg;
    logic [SW-1:0] sidx;
    logic [LW:0]   cnt_reg;
    logic [FW-1:0] fill_cur_reg, wcnt_reg;
    logic          found_reg;
    logic [63:0]   rid_reg;
    logic [15:0]   rport_reg;
    logic          hit_reg;
    rsp_t          rsp_bus;
    logic          m_valid_reg;

    assign sidx = cmd_reg.stream_index[SW-1:0];

    always_ff @(posedge aclk) begin
        if (row_we) row_mem[sidx] <= row_wr;
        row_rd_reg <= row_mem[sidx];
    end

    // Chain of cells. The tail pair either returns to the head (kept) or is
    // replaced by an empty entry (dropped); a connect appends at the end.
    cell_ctl_t ctl;
    pair_t     head_in, tail_out;
    pair_t     load_pair;
    logic      tail_match;

    actct_chain #(.MAX_LISTENERS(MAX_LISTENERS)) u_chain (
        .aclk      (aclk),
        .ctl       (ctl),
        .head_in   (head_in),
        .tail_out  (tail_out)
    );

    // During load, slot i enters the head so that after all loads slot 0
    // sits at the tail.
    always_comb begin
        load_pair.vld  = (cnt_reg < fill_cur_reg);
        load_pair.id   = row_rd_reg[cnt_reg[LW-1:0]*80 +: 64];
        load_pair.port = row_rd_reg[cnt_reg[LW-1:0]*80 + 64 +: 16];
    end

    assign tail_match = tail_out.vld && tail_out.id == cmd_reg.listener_id
                        && tail_out.port == cmd_reg.listener_port;

    logic drop;
    assign drop = (cmd_reg.func == FUNC_DISCONNECT) && tail_match;

    always_comb begin
        ctl       = '0;
        head_in   = tail_out;
        if (state_reg == S_LOAD) begin
            ctl.shift = 1'b1;
            head_in   = load_pair;
        end else if (state_reg == S_ROT) begin
            ctl.shift = 1'b1;
            head_in   = drop ? pair_t'('0) : tail_out;
        end
    end

    // Packing for write-back: compact valid pairs in order. The chain after
    // rotation has slot order from tail toward head; keep track via wcnt.
    logic [MAX_LISTENERS*80-1:0] pack_reg;

    always_comb begin
        row_wr = pack_reg;
        if (cmd_reg.func == FUNC_CONNECT && !found_reg
            && fill_cur_reg < FW'(MAX_LISTENERS)) begin
            row_wr[fill_cur_reg[LW-1:0]*80 +: 80] = {cmd_reg.listener_port,
                                                      cmd_reg.listener_id};
        end
        row_we = (state_reg == S_STORE);
    end

    logic ok_stream;
    logic [4:0] limit;
    assign limit = (stream_count_reg > 4'(MAX_STREAMS > 15 ? 15 : MAX_STREAMS))
                   ? 5'(MAX_STREAMS) : {1'b0, stream_count_reg};
    assign ok_stream = {16'd0, cmd_reg.stream_index} < {27'd0, limit};

    logic [FW-1:0] new_fill;
    always_comb begin
        new_fill = fill_cur_reg;
        if (cmd_reg.func == FUNC_DISCONNECT) new_fill = wcnt_reg;
        else if (cmd_reg.func == FUNC_CONNECT && !found_reg
                 && fill_cur_reg < FW'(MAX_LISTENERS)) new_fill = fill_cur_reg + FW'(1);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_READ;
            S_READ:  begin
                if (cmd_reg.addressed_entity_id != entity_id_reg) state_next = S_IDLE;
                else if (!ok_stream) state_next = S_RESP;
                else state_next = S_LOAD;
            end
            S_LOAD:  if (cnt_reg == (LW+1)'(MAX_LISTENERS - 1)) state_next = S_ROT;
            S_ROT:   if (cnt_reg == (LW+1)'(MAX_LISTENERS - 1)) state_next = S_STORE;
            S_STORE: state_next = S_RESP;
            S_RESP:  if (m_ready || !m_valid_reg) state_next = m_valid_reg ? S_IDLE : S_RESP;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_STREAMS; i++) fill_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_STORE) fill_reg[sidx] <= new_fill;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            else if (state_reg == S_RESP && !m_valid_reg) m_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) cmd_reg <= s_cmd;
        unique case (state_reg)
            S_READ: begin
                cnt_reg      <= '0;
                fill_cur_reg <= (ok_stream) ? fill_reg[sidx] : '0;
                found_reg    <= 1'b0;
                wcnt_reg     <= '0;
                hit_reg      <= 1'b0;
                pack_reg     <= '0;
            end
            S_LOAD: cnt_reg <= (cnt_reg == (LW+1)'(MAX_LISTENERS - 1))
                               ? '0 : cnt_reg + (LW+1)'(1);
            S_ROT: begin
                cnt_reg <= cnt_reg + (LW+1)'(1);
                // Tail pass visits slots 0..fill-1 in order.
                if (tail_match) found_reg <= 1'b1;
                if (tail_out.vld && !drop) begin
                    pack_reg[wcnt_reg[LW-1:0]*80 +: 80] <= {tail_out.port, tail_out.id};
                    wcnt_reg <= wcnt_reg + FW'(1);
                end
                if (tail_out.vld && {{(16-LW-1){1'b0}}, cnt_reg} == cmd_reg.connection_index) begin
                    hit_reg   <= 1'b1;
                    rid_reg   <= tail_out.id;
                    rport_reg <= tail_out.port;
                end
            end
            default: ;
        endcase
    end

    // Response build.
    always_comb begin
        rsp_bus.response_kind       = cmd_reg.func;
        rsp_bus.status              = ST_SUCCESS;
        rsp_bus.stream_tag          = {mac_reg, cmd_reg.stream_index};
        rsp_bus.dest_addr           = DEST_MAC_BASE | {40'd0, cmd_reg.stream_index[7:0]};
        rsp_bus.reply_listener_id   = cmd_reg.listener_id;
        rsp_bus.reply_listener_port = cmd_reg.listener_port;
        rsp_bus.connection_total    = '0;
        rsp_bus.notify              = 1'b0;
        if (!ok_stream) begin
            rsp_bus.status = ST_NO_STREAM_INDEX;
        end else begin
            unique case (cmd_reg.func)
                FUNC_CONNECT, FUNC_DISCONNECT: begin
                    rsp_bus.connection_total = 5'(fill_reg[sidx]);
                    rsp_bus.notify           = 1'b1;
                end
                FUNC_TX_STATE: ;
                FUNC_TX_CONN: begin
                    rsp_bus.connection_total = 5'(fill_reg[sidx]);
                    if (hit_reg) begin
                        rsp_bus.reply_listener_id   = rid_reg;
                        rsp_bus.reply_listener_port = rport_reg;
                    end else begin
                        rsp_bus.status = ST_NO_SUCH_CONN;
                    end
                end
                default: ;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE) && aresetn;
    assign m_valid = m_valid_reg;
    assign m_rsp   = rsp_bus;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("request accepted with response pending");
    a_resp_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == S_RESP) else $error("stray response");
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOAD || state_reg == S_ROT || state_reg == S_STORE)
        |-> fill_cur_reg <= FW'(MAX_LISTENERS)) else $error("fill overflow");
`endif
endmodule
`default_nettype wire
